[rtl/block_rms_gain_normalizer_assert.svh]
// Assertion macros for the RMS gain normaliser.
`ifndef BLOCK_RMS_GAIN_NORMALIZER_ASSERT_SVH
`define BLOCK_RMS_GAIN_NORMALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRGN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BRGN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/brgn_pkg.sv]
`timescale 1ns / 1ps
package brgn_pkg;

	localparam int SUM_W     = 37;
	localparam int CNT_W     = 7;
	localparam int IDX_W     = 6;
	localparam int RAM_DEPTH = 128;
	localparam int RAM_AW    = 7;
	localparam int TGT_W     = 24;
	localparam int DVD_W     = 53;
	localparam int DVS_W     = 27;
	localparam int GAIN_W    = 40;

	localparam logic [TGT_W-1:0] TARGET_RESET = 24'd1677696;
	localparam logic [14:0]      SAMPLE_MAX   = 15'h7FFF;

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic               end_of_clip;
	} in_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               block_last;
	} out_t;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
	} desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

[rtl/block_rms_gain_normalizer.sv]
`timescale 1ns / 1ps
// RMS gain normaliser for signed 16-bit audio.
// Input channel in_valid/in_ready/in_data carries one sample and an end-of-clip
// flag per transfer. A block closes after BLOCK_LEN samples or on end-of-clip.
// Output channel out_valid/out_ready/out_data returns every sample of a closed
// block scaled by target/RMS, with block_last on its final sample.
// Config channel cfg_valid/cfg_ready/cfg_data writes the 24-bit target (Q16.8);
// it is always ready and should be written while the block is idle.
// Samples are stored in a two-block RAM: one half fills while the other
// drains, so input transfers are accepted until both halves are busy.
// When a block closes the back end runs the mean divide, the square root
// and, unless the RMS is zero, the gain divide; then it emits the samples
// one at a time, each through RAM read, multiply, clamp and output register.
// A stalled receiver holds the output register; the back end waits, and the
// input side keeps accepting until the second RAM half is also closed.
// Reset clears the fill count, sum, queue and output valid, and loads the
// target reset value; buffered sample data is not cleared.
module block_rms_gain_normalizer #(
	parameter int BLOCK_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  brgn_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output brgn_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [brgn_pkg::TGT_W-1:0] cfg_data
);
	import brgn_pkg::*;

	`include "block_rms_gain_normalizer_assert.svh"

	logic [TGT_W-1:0]  target_q;
	q_stat_t           stat;
	logic              push;
	logic              pop;
	desc_t             desc_w;
	desc_t             head;
	logic              we;
	logic [RAM_AW-1:0] waddr;
	logic [15:0]       wdata;
	logic [RAM_AW-1:0] raddr;
	logic [15:0]       rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_valid) begin
			target_q <= cfg_data;
		end
	end

	brgn_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.stat     (stat),
		.push     (push),
		.desc     (desc_w),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata)
	);

	brgn_ram #(.WIDTH(16), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	brgn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (desc_w),
		.pop    (pop),
		.rdata  (head),
		.stat   (stat)
	);

	brgn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.target    (target_q),
		.raddr     (raddr),
		.rdata     (rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`BRGN_ASSERT_NOW(a_full_blocks_in, stat.full, !in_ready, "input taken with both halves busy")
	`BRGN_ASSERT_NOW(a_out_has_block, out_valid, !stat.empty, "output with no block queued")
	`BRGN_ASSERT_NEXT(a_eoc_queues, in_valid && in_ready && in_data.end_of_clip, !stat.empty, "end of clip did not queue a block")

endmodule

[rtl/brgn_ram.sv]
`timescale 1ns / 1ps
module brgn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/brgn_queue.sv]
`timescale 1ns / 1ps
module brgn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  brgn_pkg::desc_t   wdata,
	input  logic              pop,
	output brgn_pkg::desc_t   rdata,
	output brgn_pkg::q_stat_t stat
);
	import brgn_pkg::*;

	desc_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign rdata      = ent_q[rd_q];
	assign stat.empty = (count_q == 2'd0);
	assign stat.full  = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

endmodule

[rtl/brgn_front.sv]
`timescale 1ns / 1ps
module brgn_front #(
	parameter int BLOCK_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  brgn_pkg::in_t                 in_data,
	input  brgn_pkg::q_stat_t             stat,
	output logic                          push,
	output brgn_pkg::desc_t               desc,
	output logic                          we,
	output logic [brgn_pkg::RAM_AW-1:0]   waddr,
	output logic [15:0]                   wdata
);
	import brgn_pkg::*;

	localparam logic [CNT_W-1:0] LEN = CNT_W'(BLOCK_LEN);

	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic             bank_q;
	logic signed [31:0] sq;
	logic [SUM_W-1:0] sum_nxt;
	logic [CNT_W-1:0] fill_nxt;
	logic             fire;
	logic             close;

	assign in_ready = ~stat.full;
	assign fire     = in_valid & in_ready;
	assign sq       = in_data.sample_in * in_data.sample_in;
	assign sum_nxt  = sum_q + {{(SUM_W-32){1'b0}}, sq};
	assign fill_nxt = fill_q + 1'b1;
	assign close    = (fill_nxt == LEN) | in_data.end_of_clip;

	assign we    = fire;
	assign waddr = {bank_q, fill_q[IDX_W-1:0]};
	assign wdata = in_data.sample_in;
	assign push  = fire & close;
	assign desc  = '{bank: bank_q, n: fill_nxt, sum: sum_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
			bank_q <= 1'b0;
		end else if (fire) begin
			if (close) begin
				// hand the block over and switch to the other half
				fill_q <= '0;
				sum_q  <= '0;
				bank_q <= ~bank_q;
			end else begin
				fill_q <= fill_nxt;
				sum_q  <= sum_nxt;
			end
		end
	end

endmodule

[rtl/brgn_back.sv]
`timescale 1ns / 1ps
module brgn_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brgn_pkg::desc_t               head,
	input  brgn_pkg::q_stat_t             stat,
	output logic                          pop,
	input  logic [brgn_pkg::TGT_W-1:0]    target,
	output logic [brgn_pkg::RAM_AW-1:0]   raddr,
	input  logic [15:0]                   rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output brgn_pkg::out_t                out_data
);
	import brgn_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MEAN, S_SQRT, S_GAIN, S_RD, S_MUL, S_FIN, S_OUT
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	out_t              out_q;

	logic [DVD_W-1:0]  div_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [5:0]        cnt_q;
	logic [DVD_W-1:0]  v_q;
	logic [DVD_W-1:0]  root_q;
	logic [DVD_W-1:0]  bit_q;
	logic [GAIN_W-1:0] gain_q;
	logic [IDX_W-1:0]  idx_q;
	logic [46:0]       prod_q;
	logic              sat_q;
	logic              neg_q;

	logic [DVS_W:0]    trial;
	logic              ge;
	logic [DVS_W-1:0]  rem_nxt;
	logic [DVD_W-1:0]  div_nxt;
	logic              div_done;
	logic [DVD_W-1:0]  sq_t;
	logic              take;
	logic [DVD_W-1:0]  v_nxt;
	logic [DVD_W-1:0]  root_nxt;
	logic [15:0]       mag;
	logic [14:0]       qmag;
	logic [15:0]       qval;
	logic              last;

	// shared restoring divider, one quotient bit a cycle
	assign trial    = {rem_q, div_q[DVD_W-1]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign rem_nxt  = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
	assign div_nxt  = {div_q[DVD_W-2:0], ge};
	assign div_done = (cnt_q == 6'(DVD_W - 1));

	// square root, one result bit a cycle
	assign sq_t     = root_q + bit_q;
	assign take     = (v_q >= sq_t);
	assign v_nxt    = take ? (v_q - sq_t) : v_q;
	assign root_nxt = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);

	assign mag  = rdata[15] ? 16'(-rdata) : rdata;
	assign qmag = (sat_q || prod_q[46:31] != '0) ? SAMPLE_MAX : prod_q[30:16];
	assign qval = {1'b0, qmag};
	assign last = ((CNT_W'(idx_q) + 1'b1) == head.n);

	assign raddr     = {head.bank, idx_q};
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pop       = (state_q == S_OUT) & out_ready & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!stat.empty) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						state_q <= (root_nxt == '0) ? S_RD : S_GAIN;
					end
				end
				S_GAIN: begin
					if (div_done) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					out_q.sample_out <= neg_q ? -qval : qval;
					out_q.block_last <= last;
					out_valid_q      <= 1'b1;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= last ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				div_q <= {head.sum, 16'b0};
				rem_q <= '0;
				dvs_q <= DVS_W'(head.n);
				cnt_q <= '0;
				idx_q <= '0;
			end
			S_MEAN: begin
				div_q <= div_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + 6'd1;
				if (div_done) begin
					v_q    <= div_nxt;
					root_q <= '0;
					bit_q  <= DVD_W'(1) << (DVD_W - 1);
				end
			end
			S_SQRT: begin
				v_q    <= v_nxt;
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				// zero RMS: no gain, every output is zero
				gain_q <= '0;
				div_q  <= {{(DVD_W-TGT_W-16){1'b0}}, target, 16'b0};
				rem_q  <= '0;
				dvs_q  <= root_nxt[DVS_W-1:0];
				cnt_q  <= '0;
			end
			S_GAIN: begin
				div_q <= div_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + 6'd1;
				if (div_done) begin
					gain_q <= div_nxt[GAIN_W-1:0];
				end
			end
			S_MUL: begin
				prod_q <= {31'b0, mag} * {16'b0, gain_q[30:0]};
				sat_q  <= (gain_q[GAIN_W-1:31] != '0) && (mag != '0);
				neg_q  <= rdata[15];
			end
			S_OUT: begin
				if (out_ready) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[tb/tb_block_rms_gain_normalizer.sv]
`timescale 1ns / 1ps
module tb_block_rms_gain_normalizer;
	import brgn_pkg::*;

	localparam int BLK = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	// Expected outputs of the normaliser, with its own copy of block state.
	class gain_scoreboard;
		logic signed [15:0] held[BLK];
		int unsigned        held_n;
		logic [36:0]        energy;
		logic [23:0]        target;
		out_t               pending[$];
		int                 errors;
		int                 blocks;

		function new();
			held_n = 0;
			energy = '0;
			target = TARGET_RESET;
			errors = 0;
			blocks = 0;
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] b;
			root = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v = v - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
			return root;
		endfunction

		function void note_sample(in_t d);
			logic [63:0] rms;
			logic [63:0] gain;
			logic [63:0] mag;
			logic [63:0] q;
			out_t        o;
			int          i;
			held[held_n] = d.sample_in;
			energy = energy + 37'(int'(d.sample_in) * int'(d.sample_in));
			held_n++;
			if (held_n < BLK && !d.end_of_clip) return;
			rms = int_sqrt(({27'd0, energy} << 16) / held_n);
			gain = (rms == 0) ? 64'd0 : ({40'd0, target} << 16) / rms;
			for (i = 0; i < held_n; i++) begin
				mag = held[i] < 0 ? 64'(-int'(held[i])) : 64'(held[i]);
				q = (mag * gain) >> 16;
				if (q > 32767) q = 32767;
				o.sample_out = held[i] < 0 ? -16'(q) : 16'(q);
				o.block_last = (i + 1 == held_n);
				pending.insert(pending.size(), o);
			end
			held_n = 0;
			energy = '0;
			blocks++;
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output sample %0d last %0b", $time,
					got.sample_out, got.block_last);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sample_out !== want.sample_out) begin
				$display("%0t: sample_out expected %0d actual %0d", $time,
					want.sample_out, got.sample_out);
				errors++;
			end
			if (got.block_last !== want.block_last) begin
				$display("%0t: block_last expected %0b actual %0b", $time,
					want.block_last, got.block_last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	gain_scoreboard sb;
	int     src_idle_pct;
	int     snk_stall_pct;
	longint cycles;
	int     sent;

	block_rms_gain_normalizer #(.BLOCK_LEN(BLK)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every output transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Receiver stalls.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Valid stays high into the next transfer unless the sender idles.
	task automatic send_sample(logic signed [15:0] s, logic eoc);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= '{sample_in: s, end_of_clip: eoc};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_sample('{sample_in: s, end_of_clip: eoc});
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Write target only once the block is fully drained.
	task automatic write_target(logic [23:0] v);
		drain_all();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.target = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(64)) - 32);
			3: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_run(int count);
		int i;
		for (i = 0; i < count; i++)
			send_sample(rand_sample(), $urandom_range(99) < 8);
	endtask

	initial begin
		int i;
		sb = new();
		cycles = 0;
		sent = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, single-sample block, all-zero block, clamp.
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sh0001, 1'b1);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sh0002, 1'b1);
		write_target(24'd0);
		send_sample(16'sh1234, 1'b0);
		send_sample(16'shA5A5, 1'b1);
		write_target(24'hFFFFFF);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh5555, 1'b1);
		write_target(TARGET_RESET);

		// No idling; random samples, each closing a block with 8 percent chance.
		random_run(80);
		src_idle_pct = 48;
		random_run(70);
		// Hold the sender until everything has come out.
		drain_all();
		write_target(24'd256);
		src_idle_pct = 0;
		snk_stall_pct = 48;
		random_run(70);
		write_target(24'($urandom));
		src_idle_pct = 8;
		snk_stall_pct = 8;
		random_run(70);
		send_sample(rand_sample(), 1'b1);

		drain_all();
		$display("covered %0d samples in %0d blocks across several target settings",
			sent, sb.blocks);
		$display("idle and stall phases: none, sender, receiver, both");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
